// File: sv/lfsr_noise_sound_channel_top_macros.svh
// Assertion macros shared by the noise channel RTL.
`ifndef LFSR_NOISE_SOUND_CHANNEL_TOP_MACROS_SVH
`define LFSR_NOISE_SOUND_CHANNEL_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LNSC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Trigger condition that implies a consequent on the next clock edge.
`define LNSC_ASSERT_NEXT(lbl, clk, rstn, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cons)) else $error(msg);

`endif

// File: sv/lnsc_pkg.sv
// Package with the shared types and constants of the noise sound channel.
package lnsc_pkg;

  // Event kinds carried by an input transfer.
  typedef enum logic [1:0] {
    MODE_ENV  = 2'd0,
    MODE_LEN  = 2'd1,
    MODE_OUT  = 2'd2,
    MODE_CTRL = 2'd3
  } mode_e;

  // Configuration register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_ENV_PERIOD = 3'd0,
    REG_ENV_UP     = 3'd1,
    REG_NOISE_SHIFT = 3'd2,
    REG_NOISE_SHORT = 3'd3,
    REG_NOISE_DIV  = 3'd4
  } reg_idx_e;

  // Configuration register contents.
  typedef struct packed {
    logic [2:0] env_period;
    logic       env_up;
    logic [3:0] noise_shift;
    logic       noise_short;
    logic [2:0] noise_div;
  } cfg_t;

  localparam int unsigned AddrWidth   = 5;
  localparam int unsigned DataWidth   = 32;
  localparam int unsigned NoiseCntW   = 19;
  localparam int unsigned LfsrW       = 15;
  localparam int unsigned LenW        = 6;
  localparam logic [LfsrW-1:0] LfsrSeed = 15'h7FFF;
  localparam logic [3:0] VolumeMax     = 4'hF;
  localparam logic [3:0] ShiftFreeze   = 4'd14;
  localparam int unsigned CtrlTrigBit  = 7;
  localparam int unsigned CtrlLenEnBit = 6;
  localparam logic [5:0] DivZeroBase   = 6'd2;

endpackage

// File: sv/lfsr_noise_sound_channel_top.sv
// Noise sound channel: one event per input transfer, one result transfer per event.
// Each accepted event (envelope tick, length tick, output tick or control write,
// selected by s_axis_tuser) is applied to the channel state in the cycle it is
// accepted, and its result (held sample and channel-on flag) appears on the
// output stream in the next cycle from a result register. The block takes one
// event every clock cycle; s_axis_tready is high whenever the result register
// is empty or its content is being transferred in the same cycle, so output
// back-pressure is the only thing that slows the input. Configuration
// registers (envelope period, envelope direction, noise shift, short mode,
// divisor code) sit on the APB port at byte addresses 0, 4, 8, 12 and 16 and
// should be written only while no event is in flight.
module lfsr_noise_sound_channel_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] write_value
  input  logic [1:0]                     s_axis_tuser,  // [1:0] mode
  // Output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // [3:0] sample, [4] channel_on
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lnsc_pkg::AddrWidth-1:0] paddr,
  input  logic [lnsc_pkg::DataWidth-1:0] pwdata,
  output logic [lnsc_pkg::DataWidth-1:0] prdata,
  output logic                           pready
);

  lnsc_pkg::cfg_t cfg;
  logic           fire;
  logic           out_free;
  logic [3:0]     res_sample;
  logic           res_on;

  assign s_axis_tready = out_free;
  assign fire          = s_axis_tvalid && out_free;

  lnsc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lnsc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .mode_i        (s_axis_tuser),
    .write_value_i (s_axis_tdata),
    .cfg_i         (cfg),
    .sample_o      (res_sample),
    .channel_on_o  (res_on)
  );

  lnsc_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .sample_i      (res_sample),
    .channel_on_i  (res_on),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: sv/lnsc_cfg_regs.sv
// APB configuration register file of the noise sound channel.
module lnsc_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lnsc_pkg::AddrWidth-1:0]      paddr,
  input  logic [lnsc_pkg::DataWidth-1:0]      pwdata,
  output logic [lnsc_pkg::DataWidth-1:0]      prdata,
  output logic                                pready,
  output lnsc_pkg::cfg_t                      cfg_o
);

  lnsc_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  // Register write decode; unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[4:2])
        lnsc_pkg::REG_ENV_PERIOD:  cfg_d.env_period  = pwdata[2:0];
        lnsc_pkg::REG_ENV_UP:      cfg_d.env_up      = pwdata[0];
        lnsc_pkg::REG_NOISE_SHIFT: cfg_d.noise_shift = pwdata[3:0];
        lnsc_pkg::REG_NOISE_SHORT: cfg_d.noise_short = pwdata[0];
        lnsc_pkg::REG_NOISE_DIV:   cfg_d.noise_div   = pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back multiplexer.
  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      lnsc_pkg::REG_ENV_PERIOD:  prdata[2:0] = cfg_q.env_period;
      lnsc_pkg::REG_ENV_UP:      prdata[0]   = cfg_q.env_up;
      lnsc_pkg::REG_NOISE_SHIFT: prdata[3:0] = cfg_q.noise_shift;
      lnsc_pkg::REG_NOISE_SHORT: prdata[0]   = cfg_q.noise_short;
      lnsc_pkg::REG_NOISE_DIV:   prdata[2:0] = cfg_q.noise_div;
      default: ;
    endcase
  end

endmodule

// File: sv/lnsc_core.sv
// Channel state registers and the single-pass update for one event.
`include "lfsr_noise_sound_channel_top_macros.svh"

module lnsc_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  logic [1:0]     mode_i,
  input  logic [7:0]     write_value_i,
  input  lnsc_pkg::cfg_t cfg_i,
  output logic [3:0]     sample_o,
  output logic           channel_on_o
);

  logic [3:0]                     volume_q, volume_d;
  logic [7:0]                     env_cnt_q, env_cnt_d;
  logic [lnsc_pkg::LenW-1:0]      len_cnt_q, len_cnt_d;
  logic [7:0]                     ctrl_q, ctrl_d;
  logic [lnsc_pkg::LfsrW-1:0]     lfsr_q, lfsr_d;
  logic [lnsc_pkg::NoiseCntW-1:0] noise_cnt_q, noise_cnt_d;
  logic                           enabled_q, enabled_d;
  logic [3:0]                     held_q, held_d;

  logic [7:0]                     env_dec;
  logic [lnsc_pkg::LenW-1:0]      len_inc;
  logic [lnsc_pkg::NoiseCntW-1:0] noise_dec;
  logic [5:0]                     div_base;
  logic                           fb;
  logic [lnsc_pkg::LfsrW-1:0]     lfsr_shift;
  lnsc_pkg::mode_e                mode;

  assign mode       = lnsc_pkg::mode_e'(mode_i);
  assign env_dec    = env_cnt_q - 8'd1;
  assign len_inc    = len_cnt_q + 6'd1;
  assign noise_dec  = noise_cnt_q - 19'd1;
  assign div_base   = (cfg_i.noise_div == 3'd0) ? lnsc_pkg::DivZeroBase
                                                : {cfg_i.noise_div, 3'b000};

  // Next LFSR value: shift right, feed XOR of the two low bits into bit 14 (and bit 6 if short).
  always_comb begin
    fb         = lfsr_q[0] ^ lfsr_q[1];
    lfsr_shift = lfsr_q >> 1;
    if (cfg_i.noise_short) begin
      lfsr_shift[6] = fb;
    end
    lfsr_shift[lnsc_pkg::LfsrW-1] = fb;
  end

  // Apply one event to the channel state.
  always_comb begin
    volume_d    = volume_q;
    env_cnt_d   = env_cnt_q;
    len_cnt_d   = len_cnt_q;
    ctrl_d      = ctrl_q;
    lfsr_d      = lfsr_q;
    noise_cnt_d = noise_cnt_q;
    enabled_d   = enabled_q;
    held_d      = held_q;
    if (fire_i) begin
      unique case (mode)
        lnsc_pkg::MODE_ENV: begin
          if (cfg_i.env_period != 3'd0) begin
            env_cnt_d = env_dec;
            if (env_dec == 8'd0) begin
              env_cnt_d = {5'd0, cfg_i.env_period};
              if (cfg_i.env_up) begin
                if (volume_q != lnsc_pkg::VolumeMax) volume_d = volume_q + 4'd1;
              end else begin
                if (volume_q != 4'd0) volume_d = volume_q - 4'd1;
              end
            end
          end
        end
        lnsc_pkg::MODE_LEN: begin
          if (ctrl_q[lnsc_pkg::CtrlLenEnBit]) begin
            len_cnt_d = len_inc;
            if (len_inc == '0) enabled_d = 1'b0;
          end
        end
        lnsc_pkg::MODE_OUT: begin
          if (cfg_i.noise_shift < lnsc_pkg::ShiftFreeze) begin
            noise_cnt_d = noise_dec;
            if (noise_dec == '0) begin
              noise_cnt_d = {13'd0, div_base} << cfg_i.noise_shift;
              lfsr_d      = lfsr_shift;
              held_d      = lfsr_shift[0] ? 4'd0 : volume_q;
            end
          end
        end
        lnsc_pkg::MODE_CTRL: begin
          if (write_value_i[lnsc_pkg::CtrlTrigBit]) begin
            enabled_d = 1'b1;
            lfsr_d    = lnsc_pkg::LfsrSeed;
          end
          ctrl_d = write_value_i;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q    <= '0;
      env_cnt_q   <= '0;
      len_cnt_q   <= '0;
      ctrl_q      <= '0;
      lfsr_q      <= lnsc_pkg::LfsrSeed;
      noise_cnt_q <= 19'd1;
      enabled_q   <= 1'b0;
      held_q      <= '0;
    end else begin
      volume_q    <= volume_d;
      env_cnt_q   <= env_cnt_d;
      len_cnt_q   <= len_cnt_d;
      ctrl_q      <= ctrl_d;
      lfsr_q      <= lfsr_d;
      noise_cnt_q <= noise_cnt_d;
      enabled_q   <= enabled_d;
      held_q      <= held_d;
    end
  end

  // The result reflects the state after this event.
  assign sample_o     = held_d;
  assign channel_on_o = enabled_d;

  `LNSC_ASSERT_NEXT(a_trig_on, clk_i, rst_ni,
    fire_i && mode_i == lnsc_pkg::MODE_CTRL && write_value_i[lnsc_pkg::CtrlTrigBit],
    enabled_q && lfsr_q == lnsc_pkg::LfsrSeed, "trigger did not enable and reseed")
  `LNSC_ASSERT_NEXT(a_vol_hold, clk_i, rst_ni,
    !(fire_i && mode_i == lnsc_pkg::MODE_ENV), $stable(volume_q),
    "volume changed without an envelope tick")
  `LNSC_ASSERT_NEXT(a_held_hold, clk_i, rst_ni,
    !(fire_i && mode_i == lnsc_pkg::MODE_OUT), $stable(held_q) && $stable(noise_cnt_q),
    "noise state changed without an output tick")

endmodule

// File: sv/lnsc_out_stage.sv
// Result register with stream handshake toward the consumer.
`include "lfsr_noise_sound_channel_top_macros.svh"

module lnsc_out_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [3:0] sample_i,
  input  logic       channel_on_i,
  output logic       free_o,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata
);

  logic       valid_q, valid_d;
  logic [3:0] sample_q;
  logic       on_q;

  // The stage can take a new result when empty or when its result leaves now.
  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (fire_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      sample_q <= sample_i;
      on_q     <= channel_on_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {3'b000, on_q, sample_q};

  `LNSC_ASSERT_NEXT(a_fire_valid, clk_i, rst_ni, fire_i, valid_q,
    "accepted event produced no result")
  `LNSC_ASSERT(a_no_overrun, clk_i, rst_ni, !(fire_i && valid_q && !m_axis_tready),
    "result overwritten before transfer")

endmodule

// File: tb/tb_lfsr_noise_sound_channel_top.sv
// Self-checking testbench for the noise sound channel: random events, stalls and settings.
module tb_lfsr_noise_sound_channel_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected content of one result transfer.
  typedef struct packed {
    logic [3:0] sample;
    logic       channel_on;
  } channel_out_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata;   // [7:0] write_value
  logic [1:0]                     s_axis_tuser;   // [1:0] mode
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [7:0]                     m_axis_tdata;   // [3:0] sample, [4] channel_on
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [lnsc_pkg::AddrWidth-1:0] paddr;
  logic [lnsc_pkg::DataWidth-1:0] pwdata;
  logic [lnsc_pkg::DataWidth-1:0] prdata;
  logic                           pready;

  lfsr_noise_sound_channel_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Channel state and settings as the block should hold them.
  lnsc_pkg::cfg_t chan_cfg;
  logic [3:0]     volume;
  logic [7:0]     env_count;
  logic [5:0]     length_count;
  logic [7:0]     control_byte;
  logic [14:0]    noise_lfsr;
  logic [18:0]    noise_count;
  logic           chan_on;
  logic [3:0]     held_sample;

  channel_out_t expected_out_q[$];

  int mismatches;
  int events_sent;
  int results_checked;
  int lfsr_clocks;
  int length_cutoffs;
  int cfg_writes;
  int mode_counts[4];
  bit src_gaps_on;
  bit sink_stalls_on;
  int stall_left;

  // Clock.
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Hard limit on the run time.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Apply one accepted event to the predicted state and return the result it causes.
  function automatic channel_out_t step_channel(lnsc_pkg::mode_e ev, logic [7:0] wv);
    logic [18:0]  reload;
    logic         fb;
    channel_out_t res;
    case (ev)
      lnsc_pkg::MODE_ENV: begin
        if (chan_cfg.env_period != 3'd0) begin
          env_count = env_count - 8'd1;
          if (env_count == 8'd0) begin
            env_count = 8'(chan_cfg.env_period);
            if (chan_cfg.env_up) begin
              if (volume != lnsc_pkg::VolumeMax) volume = volume + 4'd1;
            end else if (volume != 4'd0) begin
              volume = volume - 4'd1;
            end
          end
        end
      end
      lnsc_pkg::MODE_LEN: begin
        if (control_byte[lnsc_pkg::CtrlLenEnBit]) begin
          length_count = length_count + 6'd1;
          if (length_count == 6'd0) begin
            if (chan_on) length_cutoffs++;
            chan_on = 1'b0;
          end
        end
      end
      lnsc_pkg::MODE_OUT: begin
        if (chan_cfg.noise_shift < lnsc_pkg::ShiftFreeze) begin
          noise_count = noise_count - 19'd1;
          if (noise_count == 19'd0) begin
            reload = (chan_cfg.noise_div == 3'd0) ? 19'd2 : 19'({chan_cfg.noise_div, 3'b000});
            noise_count = reload << chan_cfg.noise_shift;
            fb = noise_lfsr[0] ^ noise_lfsr[1];
            noise_lfsr = noise_lfsr >> 1;
            if (chan_cfg.noise_short) noise_lfsr[6] = fb;
            noise_lfsr[14] = fb;
            held_sample = noise_lfsr[0] ? 4'd0 : volume;
            lfsr_clocks++;
          end
        end
      end
      default: begin
        if (wv[lnsc_pkg::CtrlTrigBit]) begin
          chan_on = 1'b1;
          noise_lfsr = lnsc_pkg::LfsrSeed;
        end
        control_byte = wv;
      end
    endcase
    res.sample = held_sample;
    res.channel_on = chan_on;
    return res;
  endfunction

  // Gap length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  function automatic lnsc_pkg::mode_e pick_mode(int w_env, int w_len, int w_out);
    int r;
    r = $urandom_range(0, 99);
    if (r < w_env) return lnsc_pkg::MODE_ENV;
    if (r < w_env + w_len) return lnsc_pkg::MODE_LEN;
    if (r < w_env + w_len + w_out) return lnsc_pkg::MODE_OUT;
    return lnsc_pkg::MODE_CTRL;
  endfunction

  // Send one event; the prediction is made at the edge where the transfer happens.
  task automatic send_event(lnsc_pkg::mode_e ev, logic [7:0] wv);
    int gap;
    gap = src_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ev;
    s_axis_tdata  <= wv;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_out_q.push_back(step_channel(ev, wv));
    events_sent++;
    mode_counts[ev]++;
  endtask

  task automatic send_random(int n, int w_env, int w_len, int w_out);
    for (int i = 0; i < n; i++) begin
      send_event(pick_mode(w_env, w_len, w_out), 8'($urandom_range(0, 255)));
    end
  endtask

  // Stop sending and wait until every expected result has been transferred.
  task automatic drain_stream();
    s_axis_tvalid <= 1'b0;
    while (expected_out_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic apb_write(lnsc_pkg::reg_idx_e idx, logic [lnsc_pkg::DataWidth-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      lnsc_pkg::REG_ENV_PERIOD:  chan_cfg.env_period  = val[2:0];
      lnsc_pkg::REG_ENV_UP:      chan_cfg.env_up      = val[0];
      lnsc_pkg::REG_NOISE_SHIFT: chan_cfg.noise_shift = val[3:0];
      lnsc_pkg::REG_NOISE_SHORT: chan_cfg.noise_short = val[0];
      default:                   chan_cfg.noise_div   = val[2:0];
    endcase
    cfg_writes++;
    @(posedge clk_i);
  endtask

  task automatic set_config(int period, int up, int shift, int short_mode, int div);
    drain_stream();
    apb_write(lnsc_pkg::REG_ENV_PERIOD, 32'(period));
    apb_write(lnsc_pkg::REG_ENV_UP, 32'(up));
    apb_write(lnsc_pkg::REG_NOISE_SHIFT, 32'(shift));
    apb_write(lnsc_pkg::REG_NOISE_SHORT, 32'(short_mode));
    apb_write(lnsc_pkg::REG_NOISE_DIV, 32'(div));
  endtask

  // Every event kind at reset settings, with the control byte at its extremes.
  task automatic test_directed();
    send_event(lnsc_pkg::MODE_ENV, 8'h00);   // envelope off
    send_event(lnsc_pkg::MODE_LEN, 8'hFF);   // length disabled, data ignored
    send_event(lnsc_pkg::MODE_OUT, 8'h00);   // first divider expiry clocks the register
    send_event(lnsc_pkg::MODE_CTRL, 8'h40);  // length enable without trigger
    repeat (3) send_event(lnsc_pkg::MODE_LEN, 8'h00);
    send_event(lnsc_pkg::MODE_CTRL, 8'h80);  // trigger, length off
    send_event(lnsc_pkg::MODE_CTRL, 8'hFF);  // trigger, length on
    send_event(lnsc_pkg::MODE_CTRL, 8'h7F);  // no trigger
    repeat (4) send_event(lnsc_pkg::MODE_OUT, 8'hFF);
    send_event(lnsc_pkg::MODE_LEN, 8'h55);
    send_event(lnsc_pkg::MODE_ENV, 8'hAA);
    send_event(lnsc_pkg::MODE_CTRL, 8'h00);
    send_event(lnsc_pkg::MODE_OUT, 8'h55);
  endtask

  // Envelope up to saturation (the first step waits out the wrapped countdown), then down.
  task automatic test_envelope();
    set_config(1, 1, 0, 0, 0);
    send_event(lnsc_pkg::MODE_CTRL, 8'h80);
    repeat (272) send_event(lnsc_pkg::MODE_ENV, 8'h00);
    send_random(20, 40, 5, 50);
    set_config(3, 0, 0, 1, 0);
    send_random(60, 60, 5, 30);
    set_config(7, 1, 1, 0, 0);
    send_random(30, 50, 10, 30);
  endtask

  // Length counter runs through its wrap, which switches the channel off.
  task automatic test_length();
    set_config(2, 1, 0, 0, 1);
    send_event(lnsc_pkg::MODE_CTRL, 8'hC0);
    send_random(90, 5, 80, 10);
  endtask

  // Register clocking under both sequence lengths, several divisors and the frozen shifts.
  task automatic test_noise();
    int shifts[8] = '{0, 0, 1, 2, 14, 15, 0, 0};
    int divs[8]   = '{0, 0, 7, 3, 5, 0, 7, 1};
    for (int i = 0; i < 8; i++) begin
      set_config($urandom_range(0, 7), $urandom_range(0, 1), shifts[i], i % 2, divs[i]);
      src_gaps_on    = (i % 3 != 0);
      sink_stalls_on = (i % 4 != 1);
      send_random(30, 15, 5, 70);
    end
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  // Largest divisor comes last, since its reload outlasts the rest of the run.
  task automatic test_slow_divider();
    set_config(7, 1, 13, 1, 7);
    send_random(25, 30, 20, 40);
  endtask

  // Result sink with random back-pressure.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (sink_stalls_on && $urandom_range(0, 99) < 25) begin
      stall_left = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2) : $urandom_range(5, 29);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    channel_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_out_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: data %h", $realtime, m_axis_tdata);
      end else begin
        want = expected_out_q.pop_front();
        results_checked++;
        if (m_axis_tdata[3:0] != want.sample) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: sample expected %0d, got %0d", $realtime, want.sample,
                     m_axis_tdata[3:0]);
        end
        if (m_axis_tdata[4] != want.channel_on) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: channel_on expected %0b, got %0b", $realtime, want.channel_on,
                     m_axis_tdata[4]);
        end
      end
    end
  end

  // Test sequence.
  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    m_axis_tready  = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    chan_cfg       = '0;
    volume         = '0;
    env_count      = '0;
    length_count   = '0;
    control_byte   = '0;
    noise_lfsr     = lnsc_pkg::LfsrSeed;
    noise_count    = 19'd1;
    chan_on        = 1'b0;
    held_sample    = '0;
    mismatches     = 0;
    events_sent    = 0;
    results_checked = 0;
    lfsr_clocks    = 0;
    length_cutoffs = 0;
    cfg_writes     = 0;
    mode_counts    = '{default: 0};
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    stall_left     = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_envelope();
    test_length();
    test_noise();
    test_slow_divider();

    drain_stream();
    repeat (5) @(posedge clk_i);
    if (expected_out_q.size() != 0) mismatches++;
    $display("Sent %0d events (envelope %0d, length %0d, output %0d, control %0d), checked %0d.",
             events_sent, mode_counts[lnsc_pkg::MODE_ENV], mode_counts[lnsc_pkg::MODE_LEN],
             mode_counts[lnsc_pkg::MODE_OUT], mode_counts[lnsc_pkg::MODE_CTRL],
             results_checked);
    $display("Register clocked %0d times, length cutoffs %0d, register writes %0d.",
             lfsr_clocks, length_cutoffs, cfg_writes);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/lnsc_pkg.sv
sv/lnsc_cfg_regs.sv
sv/lnsc_core.sv
sv/lnsc_out_stage.sv
sv/lfsr_noise_sound_channel_top.sv
tb/tb_lfsr_noise_sound_channel_top.sv
